// ----- hdl/usbenc_pkg.sv -----
// usbenc_pkg: command codes, line symbol codes and constants for the USB packet line encoder.
// No dependencies.
package usbenc_pkg;

    typedef enum logic [2:0] {
        CMD_START = 3'd0,
        CMD_DATA  = 3'd1,
        CMD_CRC16 = 3'd2,
        CMD_TOKEN = 3'd3,
        CMD_HSHK  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        SYM_J   = 2'd0,
        SYM_K   = 2'd1,
        SYM_SE0 = 2'd2
    } t_sym;

    localparam logic [7:0]  SYNC_PATTERN = 8'h80;
    localparam logic [15:0] CRC16_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC16_POLY   = 16'h8005;
    localparam logic [4:0]  CRC5_INIT    = 5'h1F;
    localparam logic [4:0]  CRC5_POLY    = 5'h05;
    localparam logic [2:0]  STUFF_AFTER  = 3'd6;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 8;

    function automatic logic [15:0] bitrev16(input logic [15:0] v);
        logic [15:0] r;
        for (int i = 0; i < 16; i++) begin
            r[i] = v[15-i];
        end
        return r;
    endfunction

    function automatic logic [4:0] bitrev5(input logic [4:0] v);
        logic [4:0] r;
        for (int i = 0; i < 5; i++) begin
            r[i] = v[4-i];
        end
        return r;
    endfunction

endpackage

// ----- hdl/usb_packet_line_encoder.sv -----
// usb_packet_line_encoder: serialises USB packet commands into NRZI line symbols with bit stuffing.
// Depends on usbenc_pkg.
//
// Each accepted command is turned into line symbols by one bit-serial unit that does the NRZI
// coding, the bit stuffing and the CRC5/CRC16 update for one bit per unstalled clock. The block
// emits one symbol per cycle when the output side does not stall, and takes no new command until
// the last symbol of the current one is in the output register. Unused command codes are taken
// and emit nothing.
module usb_packet_line_encoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [7:0] pid_byte, [15:8] data_byte, [22:16] device_address, [26:23] endpoint_number
    input  logic [usbenc_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // [2:0] cmd
    input  logic [2:0]                          i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [1:0] line_symbol
    output logic [usbenc_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    // last_symbol
    output logic                                o_m_tlast
);
    import usbenc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_BITS  = 4'b0010,
        S_STUFF = 4'b0100,
        S_EOP   = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    logic [15:0] r_shift, n_shift;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_crc5_pend, n_crc5_pend;
    logic        r_eop, n_eop;
    logic        r_crc16_en, n_crc16_en;
    logic        r_crc5_en, n_crc5_en;
    logic [1:0]  r_eop_cnt, n_eop_cnt;
    logic        r_level, n_level;
    logic [2:0]  r_ones, n_ones;
    logic [15:0] r_crc16, n_crc16;
    logic [4:0]  r_crc5, n_crc5;
    logic        r_out_valid;
    t_sym        r_out_sym, n_out_sym;
    logic        r_out_last, n_out_last;

    logic        in_beat;
    logic        step;
    logic        bit_now;
    logic [2:0]  ones_inc;
    logic        stuff_due;
    logic        bits_done;
    t_cmd        cmd;

    assign o_s_tready = (r_state == S_IDLE);
    assign in_beat    = i_s_tvalid && o_s_tready;
    assign step       = (r_state != S_IDLE) && (!r_out_valid || i_m_tready);
    assign bit_now    = r_shift[0];
    assign ones_inc   = r_ones + 3'd1;
    assign stuff_due  = bit_now && (ones_inc == STUFF_AFTER);
    assign cmd        = t_cmd'(i_s_tuser);

    always_comb begin
        n_state     = r_state;
        n_shift     = r_shift;
        n_cnt       = r_cnt;
        n_crc5_pend = r_crc5_pend;
        n_eop       = r_eop;
        n_crc16_en  = r_crc16_en;
        n_crc5_en   = r_crc5_en;
        n_eop_cnt   = r_eop_cnt;
        n_level     = r_level;
        n_ones      = r_ones;
        n_crc16     = r_crc16;
        n_crc5      = r_crc5;
        n_out_sym   = r_out_sym;
        n_out_last  = r_out_last;
        bits_done   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_crc5_pend = 1'b0;
                    n_eop       = 1'b0;
                    n_crc16_en  = 1'b0;
                    n_crc5_en   = 1'b0;
                    n_eop_cnt   = 2'd0;
                    case (cmd)
                        CMD_START: begin
                            n_level = 1'b0;
                            n_ones  = 3'd0;
                            n_crc16 = CRC16_INIT;
                            n_shift = {i_s_tdata[7:0], SYNC_PATTERN};
                            n_cnt   = 5'd16;
                            n_state = S_BITS;
                        end
                        CMD_DATA: begin
                            n_shift    = {8'h00, i_s_tdata[15:8]};
                            n_cnt      = 5'd8;
                            n_crc16_en = 1'b1;
                            n_state    = S_BITS;
                        end
                        CMD_CRC16: begin
                            n_shift = bitrev16(~r_crc16);
                            n_cnt   = 5'd16;
                            n_eop   = 1'b1;
                            n_state = S_BITS;
                        end
                        CMD_TOKEN: begin
                            n_shift     = {5'h00, i_s_tdata[26:23], i_s_tdata[22:16]};
                            n_cnt       = 5'd11;
                            n_crc5      = CRC5_INIT;
                            n_crc5_en   = 1'b1;
                            n_crc5_pend = 1'b1;
                            n_eop       = 1'b1;
                            n_state     = S_BITS;
                        end
                        CMD_HSHK: begin
                            n_state = S_EOP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_BITS: begin
                if (step) begin
                    n_level   = bit_now ? r_level : ~r_level;
                    n_out_sym = n_level ? SYM_K : SYM_J;
                    n_ones    = (bit_now && !stuff_due) ? ones_inc : 3'd0;
                    if (r_crc16_en) begin
                        n_crc16 = {r_crc16[14:0], 1'b0}
                                ^ ((bit_now ^ r_crc16[15]) ? CRC16_POLY : 16'h0000);
                    end
                    if (r_crc5_en) begin
                        n_crc5 = {r_crc5[3:0], 1'b0}
                               ^ ((bit_now ^ r_crc5[4]) ? CRC5_POLY : 5'h00);
                    end
                    n_shift    = {1'b0, r_shift[15:1]};
                    n_cnt      = r_cnt - 5'd1;
                    n_out_last = 1'b0;
                    if (stuff_due) begin
                        n_state = S_STUFF;
                    end else if (r_cnt == 5'd1) begin
                        bits_done  = 1'b1;
                        n_out_last = !r_crc5_pend && !r_eop;
                    end
                end
            end
            S_STUFF: begin
                if (step) begin
                    n_level    = ~r_level;
                    n_out_sym  = n_level ? SYM_K : SYM_J;
                    n_out_last = 1'b0;
                    if (r_cnt == 5'd0) begin
                        bits_done  = 1'b1;
                        n_out_last = !r_crc5_pend && !r_eop;
                    end else begin
                        n_state = S_BITS;
                    end
                end
            end
            S_EOP: begin
                if (step) begin
                    n_eop_cnt  = r_eop_cnt + 2'd1;
                    n_out_sym  = (r_eop_cnt == 2'd2) ? SYM_J : SYM_SE0;
                    n_out_last = (r_eop_cnt == 2'd2);
                    if (r_eop_cnt == 2'd2) begin
                        n_level = 1'b0;
                        n_ones  = 3'd0;
                        n_crc16 = CRC16_INIT;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (bits_done) begin
            if (r_crc5_pend) begin
                n_shift     = {11'h000, bitrev5(n_crc5 ^ CRC5_INIT)};
                n_cnt       = 5'd5;
                n_crc5_pend = 1'b0;
                n_crc5_en   = 1'b0;
                n_state     = S_BITS;
            end else if (r_eop) begin
                n_eop_cnt = 2'd0;
                n_state   = S_EOP;
            end else begin
                n_state = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_level     <= 1'b0;
            r_ones      <= 3'd0;
            r_crc16     <= CRC16_INIT;
            r_out_valid <= 1'b0;
            r_crc5_pend <= 1'b0;
            r_eop       <= 1'b0;
            r_crc16_en  <= 1'b0;
            r_crc5_en   <= 1'b0;
            r_eop_cnt   <= 2'd0;
            r_cnt       <= 5'd0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_ones      <= n_ones;
            r_crc16     <= n_crc16;
            r_crc5_pend <= n_crc5_pend;
            r_eop       <= n_eop;
            r_crc16_en  <= n_crc16_en;
            r_crc5_en   <= n_crc5_en;
            r_eop_cnt   <= n_eop_cnt;
            r_cnt       <= n_cnt;
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift    <= n_shift;
        r_crc5     <= n_crc5;
        r_out_sym  <= n_out_sym;
        r_out_last <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W-2){1'b0}}, r_out_sym};
    assign o_m_tlast  = r_out_last;

endmodule

// ----- hdl/usbenc_checker.sv -----
// usbenc_checker: port-level assertions for usb_packet_line_encoder, with its bind.
// Depends on usbenc_pkg.
module usbenc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic [2:0]                        i_s_tuser,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [usbenc_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input logic                              o_m_tlast
);
    import usbenc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output beat changed while stalled");

    a_sym_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[1:0] == SYM_J || o_m_tdata[1:0] == SYM_K
                        || o_m_tdata[1:0] == SYM_SE0))
        else $error("undefined line symbol");

    a_se0_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[1:0] == SYM_SE0) |-> !o_m_tlast)
        else $error("EOP ended on SE0");

    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser == CMD_START || i_s_tuser == CMD_DATA
            || i_s_tuser == CMD_CRC16 || i_s_tuser == CMD_TOKEN || i_s_tuser == CMD_HSHK)
        |=> !o_s_tready)
        else $error("valid command accepted without going busy");

endmodule

bind usb_packet_line_encoder usbenc_checker u_usbenc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

// ----- tb/usb_packet_line_encoder_checker.sv -----
// usb_packet_line_encoder_checker: watches both stream channels of the packet line encoder,
// predicts the line symbols of every accepted command and compares each output beat.
// Depends on usbenc_pkg.
module usb_packet_line_encoder_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // [7:0] pid_byte, [15:8] data_byte, [22:16] device_address, [26:23] endpoint_number
    input  logic [31:0] i_s_tdata,
    // [2:0] cmd
    input  logic [2:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // [1:0] line_symbol
    input  logic [7:0]  i_m_tdata,
    // last_symbol
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_symbols_due
);

    import usbenc_pkg::*;

    typedef struct packed {
        t_sym sym;
        logic last;
    } t_line_beat;

    t_line_beat  symbols_due[$];
    t_line_beat  got_beat;
    logic        line_lvl;
    logic [2:0]  ones_cnt;
    logic [15:0] crc16_acc;
    int          fail_count;

    function automatic void queue_beat(input t_line_beat b);
        symbols_due.insert(symbols_due.size(), b);
    endfunction

    function automatic void put_level();
        t_line_beat b;
        b.sym  = line_lvl ? SYM_K : SYM_J;
        b.last = 1'b0;
        queue_beat(b);
    endfunction

    function automatic void put_toggle();
        line_lvl = ~line_lvl;
        put_level();
    endfunction

    function automatic void put_bit(input logic b);
        if (b) begin
            put_level();
            ones_cnt = ones_cnt + 3'd1;
            if (ones_cnt >= STUFF_AFTER) begin
                ones_cnt = 3'd0;
                put_toggle();
            end
        end else begin
            ones_cnt = 3'd0;
            put_toggle();
        end
    endfunction

    function automatic void put_eop();
        t_line_beat b;
        b.last = 1'b0;
        b.sym  = SYM_SE0;
        queue_beat(b);
        queue_beat(b);
        b.sym  = SYM_J;
        queue_beat(b);
        line_lvl  = 1'b0;
        ones_cnt  = 3'd0;
        crc16_acc = CRC16_INIT;
    endfunction

    function automatic void crc16_take(input logic [7:0] d);
        logic fb;
        for (int i = 0; i < 8; i++) begin
            fb        = d[i] ^ crc16_acc[15];
            crc16_acc = {crc16_acc[14:0], 1'b0};
            if (fb) crc16_acc = crc16_acc ^ CRC16_POLY;
        end
    endfunction

    function automatic logic [4:0] token_crc5(input logic [10:0] f);
        logic [4:0] c;
        logic       fb;
        c = CRC5_INIT;
        for (int i = 0; i < 11; i++) begin
            fb = f[i] ^ c[4];
            c  = {c[3:0], 1'b0};
            if (fb) c = c ^ CRC5_POLY;
        end
        return ~c;
    endfunction

    function automatic void predict_line_symbols(input logic [2:0] cmd, input logic [31:0] d);
        logic [15:0] crc_out;
        logic [10:0] fields;
        logic [4:0]  crc5;
        t_line_beat  tail;
        int          n0;
        n0 = symbols_due.size();
        case (cmd)
            CMD_START: begin
                line_lvl  = 1'b0;
                ones_cnt  = 3'd0;
                crc16_acc = CRC16_INIT;
                for (int i = 0; i < 8; i++) put_bit(SYNC_PATTERN[i]);
                for (int i = 0; i < 8; i++) put_bit(d[i]);
            end
            CMD_DATA: begin
                for (int i = 0; i < 8; i++) put_bit(d[8 + i]);
                crc16_take(d[15:8]);
            end
            CMD_CRC16: begin
                crc_out = ~crc16_acc;
                for (int i = 15; i >= 0; i--) put_bit(crc_out[i]);
                put_eop();
            end
            CMD_TOKEN: begin
                fields = {d[26:23], d[22:16]};
                crc5   = token_crc5(fields);
                for (int i = 0; i < 11; i++) put_bit(fields[i]);
                for (int i = 4; i >= 0; i--) put_bit(crc5[i]);
                put_eop();
            end
            CMD_HSHK: put_eop();
            default: ;
        endcase
        if (symbols_due.size() > n0) begin
            tail      = symbols_due[$];
            tail.last = 1'b1;
            symbols_due[$] = tail;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            line_lvl  = 1'b0;
            ones_cnt  = 3'd0;
            crc16_acc = CRC16_INIT;
            symbols_due.delete();
            fail_count = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) predict_line_symbols(i_s_tuser, i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                if (symbols_due.size() == 0) begin
                    $error("line_symbol: expected none, got %0d", i_m_tdata[1:0]);
                    fail_count++;
                end else begin
                    got_beat = symbols_due.pop_front();
                    if (i_m_tdata[1:0] !== got_beat.sym) begin
                        $error("line_symbol: expected %0d, got %0d", got_beat.sym,
                               i_m_tdata[1:0]);
                        fail_count++;
                    end
                    if (i_m_tlast !== got_beat.last) begin
                        $error("last_symbol: expected %0d, got %0d", got_beat.last, i_m_tlast);
                        fail_count++;
                    end
                end
            end
        end
        o_fail_count  <= fail_count;
        o_symbols_due <= symbols_due.size();
    end

endmodule

// ----- tb/tb_usb_packet_line_encoder.sv -----
// tb_usb_packet_line_encoder: drives packet commands into the USB line encoder with random
// gaps and output stalls, and reports the verdict from the checker's failure count.
// Depends on usbenc_pkg, usb_packet_line_encoder and usb_packet_line_encoder_checker.
module tb_usb_packet_line_encoder;

    import usbenc_pkg::*;

    localparam logic [2:0] CMD_SPARE_A = 3'd5;
    localparam logic [2:0] CMD_SPARE_B = 3'd6;
    localparam logic [2:0] CMD_SPARE_C = 3'd7;
    localparam int RANDOM_ITEMS = 180;
    localparam int RX_HOLD_CYCLES = 400;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;
    logic [2:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;
    logic        o_m_tlast;

    int fail_count;
    int symbols_due;
    int items_sent;
    bit calm;
    bit rx_hold_req;

    usb_packet_line_encoder u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    usb_packet_line_encoder_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .i_m_tlast     (o_m_tlast),
        .o_fail_count  (fail_count),
        .o_symbols_due (symbols_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(20 * 1000000);
        $display("FAILURE");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 6);
        return $urandom_range(12, 40);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0) return 8'hFF;
        if (r == 1) return 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    // receiver: random stalls, one long hold on request
    initial begin
        i_m_tready <= 1'b0;
        forever begin
            if (rx_hold_req) begin
                i_m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 99) < 25) begin
                i_m_tready <= 1'b0;
                repeat (pick_stall()) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic offer(input logic [2:0] cmd, input logic [7:0] pid, input logic [7:0] dat,
                         input logic [6:0] addr, input logic [3:0] endp);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {5'd0, endp, addr, dat, pid};
        do @(posedge i_clk); while (!o_s_tready);
        if (cmd <= CMD_HSHK) items_sent++;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic offer_cmd(input logic [2:0] cmd);
        offer(cmd, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              7'($urandom_range(0, 127)), 4'($urandom_range(0, 15)));
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (symbols_due != 0) @(posedge i_clk);
    endtask

    task automatic send_packet();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 85 || kind >= 93)
            offer(CMD_START, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  7'($urandom_range(0, 127)), 4'($urandom_range(0, 15)));
        if (kind < 45 || kind >= 93) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 16) : $urandom_range(0, 5);
            repeat (n)
                offer(CMD_DATA, 8'($urandom_range(0, 255)), pick_byte(),
                      7'($urandom_range(0, 127)), 4'($urandom_range(0, 15)));
            if (kind < 45) offer_cmd(CMD_CRC16);
        end else if (kind < 70) begin
            offer_cmd(CMD_TOKEN);
        end else if (kind < 85) begin
            offer_cmd(CMD_HSHK);
        end else begin
            offer_cmd(3'($urandom_range(0, 7)));
        end
    endtask

    initial begin
        bit hold_done;
        bit pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        calm       = 1'b0;
        rx_hold_req = 1'b0;
        items_sent = 0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= CMD_START;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // stuffing runs across bytes, then CRC16 of the result
        offer(CMD_START, 8'h00, 8'h00, 7'd0, 4'd0);
        offer(CMD_DATA, 8'h00, 8'hFF, 7'd0, 4'd0);
        offer(CMD_DATA, 8'h00, 8'hFF, 7'd0, 4'd0);
        offer(CMD_DATA, 8'h00, 8'h00, 7'd0, 4'd0);
        offer(CMD_CRC16, 8'h00, 8'h00, 7'd0, 4'd0);
        offer(CMD_START, 8'hFF, 8'h00, 7'd0, 4'd0);
        offer(CMD_TOKEN, 8'h00, 8'h00, 7'd127, 4'd15);
        offer(CMD_START, 8'h00, 8'hFF, 7'd127, 4'd15);
        offer(CMD_TOKEN, 8'hFF, 8'hFF, 7'd0, 4'd0);
        offer(CMD_START, 8'hD2, 8'h00, 7'd0, 4'd0);
        offer(CMD_HSHK, 8'h00, 8'h00, 7'd0, 4'd0);
        // packet restarted before it was finished
        offer(CMD_START, 8'h69, 8'h00, 7'd0, 4'd0);
        offer(CMD_DATA, 8'h00, 8'h7E, 7'd0, 4'd0);
        offer(CMD_START, 8'h2D, 8'h00, 7'd0, 4'd0);
        offer(CMD_DATA, 8'h00, 8'h3C, 7'd0, 4'd0);
        offer(CMD_CRC16, 8'h00, 8'h00, 7'd0, 4'd0);
        // commands out of order, no start beforehand
        offer(CMD_DATA, 8'h00, 8'hA5, 7'd0, 4'd0);
        offer(CMD_TOKEN, 8'h00, 8'h00, 7'h55, 4'h9);
        offer(CMD_CRC16, 8'h00, 8'h00, 7'd0, 4'd0);
        offer(CMD_HSHK, 8'h00, 8'h00, 7'd0, 4'd0);
        offer(CMD_SPARE_A, 8'hFF, 8'hFF, 7'd127, 4'd15);
        offer(CMD_SPARE_B, 8'h00, 8'h00, 7'd0, 4'd0);
        offer(CMD_SPARE_C, 8'hFF, 8'hFF, 7'd127, 4'd15);
        offer(CMD_START, 8'hE1, 8'h00, 7'd0, 4'd0);
        offer(CMD_CRC16, 8'h00, 8'h00, 7'd0, 4'd0);

        while (items_sent < RANDOM_ITEMS) begin
            if (!hold_done && items_sent >= 60) begin
                rx_hold_req = 1'b1;
                hold_done   = 1'b1;
            end
            if (!pause_done && items_sent >= 120) begin
                i_s_tvalid <= 1'b0;
                wait_drained();
                pause_done = 1'b1;
            end
            calm = (items_sent >= 140 && items_sent < 165);
            send_packet();
        end
        calm = 1'b0;
        i_s_tvalid <= 1'b0;
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
